// ===== sv/tpo_pkg.sv =====
// Package for the timestamped phase oscillator: types, constants and the
// quarter-wave sine table. It depends on nothing else.
package tpo_pkg;

  // Quarter-wave table resolution in index bits.
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_N       = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

  // Frequencies below this Q16.16 value (0.001 Hz) freeze the oscillator.
  localparam logic [31:0] MIN_FREQ = 32'd66;

  // Phase scale 2^48/1000 rounded: a 7-bit high part and a 32-bit low word.
  localparam logic [6:0]  SCALE_HI = 7'd65;
  localparam logic [31:0] SCALE_LO = 32'h8937_4BC7;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [15:0] LEVEL_MID = 16'h8000;
  localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_MUL0  = 3'd1,
    S_MUL1  = 3'd2,
    S_MUL2  = 3'd3,
    S_PHASE = 3'd4,
    S_READ  = 3'd5,
    S_OUT   = 3'd6
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new beat
    logic mul0;       // delta times frequency
    logic mul1;       // low product word times low scale word
    logic mul2;       // high product word times low scale word
    logic phase_upd;  // add the step to the phase
    logic rom_rd;     // look up the sine table
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic freq_low;
  } status_t;

  typedef logic [15:0] sine_rom_t [0:QUARTER_N];

  // Restoring shift-and-subtract division used while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds the table with an integer Taylor series; evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] div;
    for (int i = 0; i <= QUARTER_N; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 10; k++) begin
        div  = 64'((2 * k) * (2 * k + 1));
        term = udiv64((term * x2) >> 30, div);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      t = (sum + 64'd16384) >> 15;
      if (t > 64'd32768) begin
        t = 64'd32768;
      end
      rom[i] = t[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== sv/timestamped_phase_oscillator.sv =====
// Top level of the timestamped phase oscillator: joins the controller and
// the datapath. Depends on tpo_pkg, tpo_ctrl and tpo_datapath.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ----------------------------
//   input     in_valid_i / in_stall_o time_ms_i[31:0], freq_hz_i[31:0]
//   output    out_valid_o/out_stall_i level_o[15:0]
//   config    cfg_we_i                cfg_wdata_i[1:0] (waveform)
//
// An item steps from acceptance to the next acceptance through the accept
// cycle, three passes through the one shared 32x32 multiplier, the phase
// add, a registered sine table read and the result load. An item with a
// frequency below 0.001 Hz goes straight from acceptance to the result load.
// Reset clears the phase, the last timestamp and the waveform select (sine).
// A stalled output beat holds in the result register; the next item is taken
// meanwhile and waits only at its own result load until that register frees.
module timestamped_phase_oscillator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] time_ms_i,
  input  logic [31:0] freq_hz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] level_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  tpo_pkg::cmd_t    cmd;
  tpo_pkg::status_t sts;

  // The controller steps through the multiply, phase and table sequence.
  tpo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the oscillator state and the result register.
  tpo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .time_ms_i   (time_ms_i),
    .freq_hz_i   (freq_hz_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .level_o     (level_o)
  );

endmodule

// ===== sv/tpo_ctrl.sv =====
// Controller of the timestamped phase oscillator: sequences the datapath and
// owns the input and output handshakes. Depends on tpo_pkg.
module tpo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  tpo_pkg::status_t sts_i,
  output tpo_pkg::cmd_t    cmd_o
);

  tpo_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != tpo_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpo_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      tpo_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.freq_low ? tpo_pkg::S_OUT : tpo_pkg::S_MUL0;
        end
      end
      tpo_pkg::S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = tpo_pkg::S_MUL1;
      end
      tpo_pkg::S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = tpo_pkg::S_MUL2;
      end
      tpo_pkg::S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = tpo_pkg::S_PHASE;
      end
      tpo_pkg::S_PHASE: begin
        cmd_o.phase_upd = 1'b1;
        state_d         = tpo_pkg::S_READ;
      end
      tpo_pkg::S_READ: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = tpo_pkg::S_OUT;
      end
      tpo_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tpo_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tpo_pkg::S_IDLE;
      end
    endcase
  end

  // A result must never overwrite a beat that is still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending beat");

  // A frozen-frequency beat skips the arithmetic entirely.
  a_low_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.freq_low) |=> (state_q == tpo_pkg::S_OUT))
    else $error("low frequency beat entered the multiply sequence");

  // Every loaded result raises valid on the next cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

// ===== sv/tpo_datapath.sv =====
// Datapath of the timestamped phase oscillator: shared multiplier, phase
// state, sine table read and waveform shaping. Depends on tpo_pkg.
module tpo_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpo_pkg::cmd_t    cmd_i,
  output tpo_pkg::status_t sts_o,
  input  logic [31:0]      time_ms_i,
  input  logic [31:0]      freq_hz_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  output logic [15:0]      level_o
);

  logic [1:0]  waveform_q;
  logic [31:0] phase_q, last_time_q;
  logic [31:0] time_q, delta_q, freq_q;
  logic        freq_low_q;
  logic [63:0] prod_q;
  logic [31:0] plo_q, phi_q, step_q;
  logic [15:0] rom_q;
  logic [15:0] level_q, level_d;

  logic [31:0] mul_a, mul_b;
  logic [31:0] phi_d;
  logic [31:0] step_d;
  logic [31:0] scale_hi_part;

  logic [tpo_pkg::SINE_TABLE_BITS-1:0] frac;
  logic [tpo_pkg::ROM_ADDR_W-1:0]      rom_addr;

  logic [16:0] sine_up;
  logic [15:0] sine_pos, sine_neg, sine_lvl;
  logic [32:0] tri_neg;
  logic [15:0] tri_lvl;

  assign sts_o.freq_low = (freq_hz_i < tpo_pkg::MIN_FREQ);
  assign level_o        = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q  <= tpo_pkg::WAVE_SINE;
      phase_q     <= '0;
      last_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        waveform_q <= cfg_wdata_i;
      end
      if (cmd_i.phase_upd) begin
        phase_q     <= phase_q + step_q + prod_q[31:0];
        last_time_q <= time_q;
      end
    end
  end

  // Shared 32x32 multiplier; its operands change with the sequence step.
  always_comb begin
    mul_a = delta_q;
    mul_b = freq_q;
    if (cmd_i.mul1) begin
      mul_a = prod_q[31:0];
      mul_b = tpo_pkg::SCALE_LO;
    end else if (cmd_i.mul2) begin
      mul_a = phi_q;
      mul_b = tpo_pkg::SCALE_LO;
    end
  end

  // The signed delta only changes the high word of delta times frequency.
  assign phi_d         = prod_q[63:32] - (delta_q[31] ? freq_q : 32'd0);
  assign scale_hi_part = 32'(plo_q * tpo_pkg::SCALE_HI);
  assign step_d        = prod_q[63:32] + scale_hi_part;

  assign frac     = phase_q[29 -: tpo_pkg::SINE_TABLE_BITS];
  assign rom_addr = phase_q[30]
                  ? tpo_pkg::ROM_ADDR_W'(tpo_pkg::QUARTER_N) - {1'b0, frac}
                  : {1'b0, frac};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q    <= time_ms_i - last_time_q;
      time_q     <= time_ms_i;
      freq_q     <= freq_hz_i;
      freq_low_q <= sts_o.freq_low;
    end
    if (cmd_i.mul0 || cmd_i.mul1 || cmd_i.mul2) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.mul1) begin
      plo_q <= prod_q[31:0];
      phi_q <= phi_d;
    end
    if (cmd_i.mul2) begin
      step_q <= step_d;
    end
    if (cmd_i.rom_rd) begin
      rom_q <= tpo_pkg::SINE_ROM[rom_addr];
    end
    if (cmd_i.out_load) begin
      level_q <= level_d;
    end
  end

  // Waveform shaping from the updated phase.
  always_comb begin
    sine_up  = {1'b0, tpo_pkg::LEVEL_MID} + {1'b0, rom_q};
    sine_pos = sine_up[16] ? tpo_pkg::LEVEL_MAX : sine_up[15:0];
    sine_neg = tpo_pkg::LEVEL_MID - rom_q;
    sine_lvl = phase_q[31] ? sine_neg : sine_pos;

    tri_neg = 33'h1_0000_0000 - {1'b0, phase_q};
    if (!phase_q[31]) begin
      tri_lvl = phase_q[30:15];
    end else if (tri_neg[32:31] != 2'b00) begin
      tri_lvl = tpo_pkg::LEVEL_MAX;
    end else begin
      tri_lvl = tri_neg[30:15];
    end

    level_d = '0;
    if (!freq_low_q) begin
      case (waveform_q)
        tpo_pkg::WAVE_SINE:     level_d = sine_lvl;
        tpo_pkg::WAVE_SQUARE:   level_d = phase_q[31] ? 16'd0 : tpo_pkg::LEVEL_MAX;
        tpo_pkg::WAVE_TRIANGLE: level_d = tri_lvl;
        default:                level_d = '0;
      endcase
    end
  end

  // A frozen-frequency beat always reports a zero level.
  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && freq_low_q) |=> (level_q == 16'd0))
    else $error("low frequency beat produced a nonzero level");

  // The phase only moves on its update step.
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.phase_upd |=> $stable(phase_q))
    else $error("phase changed outside its update step");

  // The square wave is always at one of its two rails.
  a_square_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !freq_low_q && waveform_q == tpo_pkg::WAVE_SQUARE)
    |=> (level_q == tpo_pkg::LEVEL_MAX || level_q == 16'd0))
    else $error("square wave off its rails");

endmodule
